@@ src/bisq_pkg.sv @@
`default_nettype none
package bisq_pkg;

  // Modulus that the configuration register holds after reset.
  localparam logic [63:0] RESET_MODULUS = 64'd1000000007;

endpackage
`default_nettype wire

@@ src/bisq_if.sv @@
`default_nettype none
interface bisq_req_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] choose_count;
  logic [VALUE_BITS-1:0] square_value;

  modport source (output valid, output choose_count, output square_value, input ready);
  modport sink (input valid, input choose_count, input square_value, output ready);
endinterface

interface bisq_res_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] binomial_mod;

  modport source (output valid, output binomial_mod, input ready);
  modport sink (input valid, input binomial_mod, output ready);
endinterface
`default_nettype wire

@@ src/binomial_of_isqrt_mod_prime.sv @@
`default_nettype none
// Binomial coefficient of an integer square root, modulo a configurable prime.
// Each request carries a count n and a value x; the block forms m = isqrt(x)
// exactly and returns C(m, n) mod p, or 0 when m < n or p < 2. All modular
// products run on a single shift-and-add modular multiplier that retires
// one multiplier bit per cycle, driven by a small sequencer. A modular product
// is issued, steps through the significant bits of the multiplier, ends when
// the multiplier runs out, and is written back. One request first forms the
// root, then takes m products for m!, up to 2*VALUE_BITS products for the
// Fermat inverse, m products for the downward walk, and two final products.
// In the factorial and the downward walk the multiplier is at most m; with the
// default 31-bit width the largest root is 46340. A request whose root is
// below n, or whose modulus is below two, finishes right after the root. The
// block takes one request at a time and holds ready low until the result has
// been taken. The user must write the modulus register with cfg_we and
// cfg_data only while the block is idle; the block does not enforce this. The
// register resets to 1000000007.
module binomial_of_isqrt_mod_prime #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bisq_req_if.sink                   request,
  bisq_res_if.source                 result,
  input  wire logic                  cfg_we,
  input  wire logic [VALUE_BITS-1:0] cfg_data
);
  import bisq_pkg::*;

  localparam int W    = VALUE_BITS;
  localparam int HB   = (W + 1) / 2;          // width of the root
  localparam int TOPB = ((W - 1) / 2) * 2;    // first trial bit of the root

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_CHECK, S_FACT, S_FACT_WB, S_POW, S_POW_R, S_POW_B,
    S_DOWN, S_DOWN_WB, S_FIN_A, S_FIN_B, S_MUL, S_DONE
  } state_t;

  state_t          state, ret;
  logic [W-1:0]    modulus;
  logic [W-1:0]    p, n, rem, res, sbit;
  logic [HB-1:0]   m, k, cnt;
  logic [W-1:0]    imod, fact, r, base, e, inv_n, inv_k, ans;
  logic [W-1:0]    ma, mb, acc;

  // Shared arithmetic: modular additions for the multiplier, the root's trial sum, and the counter steps.
  logic [W:0]      acc_sum, a_sum, root_trial, inc_imod;
  logic [W-1:0]    acc_add, a_dbl;
  logic [HB-1:0]   cnt_m1;

  always_comb begin
    acc_sum    = {1'b0, acc} + {1'b0, ma};
    acc_add    = (acc_sum >= {1'b0, p}) ? W'(acc_sum - {1'b0, p}) : acc_sum[W-1:0];
    a_sum      = {1'b0, ma} + {1'b0, ma};
    a_dbl      = (a_sum >= {1'b0, p}) ? W'(a_sum - {1'b0, p}) : a_sum[W-1:0];
    root_trial = {1'b0, res} + {1'b0, sbit};
    inc_imod   = {1'b0, imod} + {{W{1'b0}}, 1'b1};
    cnt_m1     = cnt - HB'(1);
  end

  assign request.ready       = (state == S_IDLE);
  assign result.valid        = (state == S_DONE);
  assign result.binomial_mod = ans;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      modulus <= RESET_MODULUS[W-1:0];
    end else begin
      if (cfg_we) begin
        modulus <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            n     <= request.choose_count;
            rem   <= request.square_value;
            res   <= '0;
            sbit  <= W'(1) << TOPB;
            p     <= modulus;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if ({1'b0, rem} >= root_trial) begin
            rem <= W'({1'b0, rem} - root_trial);
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[1:0] != 2'b00) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          m <= res[HB-1:0];
          if (p < W'(2) || res < n) begin
            ans   <= '0;
            state <= S_DONE;
          end else begin
            k     <= HB'(res - n);
            fact  <= W'(1);
            cnt   <= '0;
            imod  <= '0;
            state <= S_FACT;
          end
        end
        S_FACT: begin
          if (cnt == m) begin
            r     <= W'(1);
            base  <= fact;
            e     <= p - W'(2);
            state <= S_POW;
          end else begin
            cnt   <= cnt + HB'(1);
            ma    <= fact;
            mb    <= (inc_imod == {1'b0, p}) ? '0 : inc_imod[W-1:0];
            imod  <= (inc_imod == {1'b0, p}) ? '0 : inc_imod[W-1:0];
            acc   <= '0;
            ret   <= S_FACT_WB;
            state <= S_MUL;
          end
        end
        S_FACT_WB: begin
          fact  <= acc;
          state <= S_FACT;
        end
        S_POW: begin
          if (e == '0) begin
            inv_n <= (n == W'(m)) ? r : '0;
            inv_k <= (k == m) ? r : '0;
            state <= S_DOWN;
          end else if (e[0]) begin
            ma <= r; mb <= base; acc <= '0;
            ret <= S_POW_R; state <= S_MUL;
          end else begin
            ma <= base; mb <= base; acc <= '0;
            ret <= S_POW_B; state <= S_MUL;
          end
        end
        S_POW_R: begin
          r  <= acc;
          ma <= base; mb <= base; acc <= '0;
          ret <= S_POW_B; state <= S_MUL;
        end
        S_POW_B: begin
          base  <= acc;
          e     <= e >> 1;
          state <= S_POW;
        end
        S_DOWN: begin
          if (cnt == '0) begin
            ma <= fact; mb <= inv_n; acc <= '0;
            ret <= S_FIN_A; state <= S_MUL;
          end else begin
            ma <= r; mb <= imod; acc <= '0;
            ret <= S_DOWN_WB; state <= S_MUL;
          end
        end
        S_DOWN_WB: begin
          r <= acc;
          if (W'(cnt_m1) == n) inv_n <= acc;
          if (cnt_m1 == k) inv_k <= acc;
          cnt   <= cnt_m1;
          imod  <= (imod == '0) ? p - W'(1) : imod - W'(1);
          state <= S_DOWN;
        end
        S_FIN_A: begin
          ma <= acc; mb <= inv_k; acc <= '0;
          ret <= S_FIN_B; state <= S_MUL;
        end
        S_FIN_B: begin
          ans   <= acc;
          state <= S_DONE;
        end
        S_MUL: begin
          // One multiplier bit per cycle: acc += a when the bit is set, a doubles.
          if (mb == '0) begin
            state <= ret;
          end else begin
            if (mb[0]) acc <= acc_add;
            ma <= a_dbl;
            mb <= mb >> 1;
          end
        end
        S_DONE: begin
          if (result.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A delivered result is always a residue of the active modulus.
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.binomial_mod == '0 || result.binomial_mod < p))
    else $error("result not reduced");
  // The multiplier accumulator stays reduced while it runs.
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && mb != '0) |-> (acc < p))
    else $error("accumulator out of range");
  // A request is never taken while a result is still offered.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(request.ready && result.valid))
    else $error("ready while result pending");
  // Once a result is offered it stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.binomial_mod)))
    else $error("result dropped");
`endif

endmodule
`default_nettype wire

@@ bench/tb_binomial_of_isqrt_mod_prime.sv @@
`default_nettype none
module tb_binomial_of_isqrt_mod_prime;

  localparam int VALUE_BITS = 31;
  // Cycle limit after which the run is declared failed.
  localparam longint unsigned CYCLE_LIMIT = 8000000;
  // Within this window of cycles neither side idles.
  localparam longint unsigned CALM_FROM = 30000;
  localparam longint unsigned CALM_TO = 150000;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t choose_count;
    value_t square_value;
  } request_t;

  logic clk;
  logic rst;
  logic cfg_we;
  value_t cfg_data;

  bisq_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
  bisq_res_if #(.VALUE_BITS(VALUE_BITS)) res_ch ();

  binomial_of_isqrt_mod_prime #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch.sink),
    .result  (res_ch.source),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // Requests waiting to be driven, and binomials still owed by the block.
  request_t pending_requests[$];
  value_t expected_binomials[$];
  // The testbench's copy of the modulus register.
  longint unsigned modulus_copy;
  longint unsigned cycle_count;
  bit any_failure;
  bit req_taken;

  always begin
    #5 clk = ~clk;
  end

  initial begin
    clk = 1'b0;
  end

  function automatic bit calm_window();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  function automatic bit idle_roll();
    return !calm_window() && ($urandom_range(0, 99) < 17);
  endfunction

  // Exact integer square root, by binary search over the root bits.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned power_mod(longint unsigned base, longint unsigned e,
                                                longint unsigned p);
    longint unsigned acc;
    acc = 1 % p;
    base = base % p;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * base) % p;
      end
      base = (base * base) % p;
      e = e >> 1;
    end
    return acc;
  endfunction

  // C(isqrt(x), n) mod p, built the way the block builds it: m!, its Fermat
  // inverse, then a downward walk that picks up the inverses of n! and (m-n)!.
  // With a composite or a small modulus the same steps run unchanged.
  function automatic value_t binomial_of_root(request_t rq, longint unsigned p);
    longint unsigned n;
    longint unsigned m;
    longint unsigned k;
    longint unsigned fact;
    longint unsigned inv;
    longint unsigned inv_n;
    longint unsigned inv_k;
    n = rq.choose_count;
    m = root_floor(rq.square_value);
    if (p < 2 || m < n) begin
      return '0;
    end
    k = m - n;
    fact = 1 % p;
    for (longint unsigned i = 1; i <= m; i++) begin
      fact = (fact * (i % p)) % p;
    end
    inv = power_mod(fact, p - 2, p);
    inv_n = (n == m) ? inv : 0;
    inv_k = (k == m) ? inv : 0;
    for (longint unsigned i = m; i > 0; i--) begin
      inv = (inv * (i % p)) % p;
      if (i - 1 == n) inv_n = inv;
      if (i - 1 == k) inv_k = inv;
    end
    return value_t'((((fact * inv_n) % p) * inv_k) % p);
  endfunction

  // Request driver: a new request goes out at the falling edge after the
  // previous one was accepted, unless this cycle is an idle one or none is waiting.
  always @(negedge clk) begin : request_driver
    request_t next_rq;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_requests.size() > 0 && !idle_roll()) begin
        next_rq = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.choose_count <= next_rq.choose_count;
        req_ch.square_value <= next_rq.square_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side stalls at random, apart from the calm window.
  always @(negedge clk) begin
    res_ch.ready <= !rst && !idle_roll();
  end

  // At each rising edge, accepted requests are predicted and accepted results
  // are checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    request_t seen;
    value_t want;
    cycle_count <= cycle_count + 1;
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      seen.choose_count = req_ch.choose_count;
      seen.square_value = req_ch.square_value;
      expected_binomials.push_back(binomial_of_root(seen, modulus_copy));
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_binomials.size() == 0) begin
        $error("unexpected result: binomial_mod %0d with no request outstanding",
               res_ch.binomial_mod);
        any_failure = 1'b1;
      end else begin
        want = expected_binomials.pop_front();
        if (res_ch.binomial_mod !== want) begin
          $error("binomial_mod mismatch: expected %0d, actual %0d", want,
                 res_ch.binomial_mod);
          any_failure = 1'b1;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binomial_of_isqrt_mod_prime regression: fail");
      $finish;
    end
  end

  task automatic queue_request(longint unsigned n, longint unsigned x);
    request_t rq;
    rq.choose_count = value_t'(n);
    rq.square_value = value_t'(x);
    pending_requests.push_back(rq);
  endtask

  // Mostly small roots with n up to one above the root, so that the block runs
  // the full factorial and inverse path; the rest are large values with n above
  // the largest root, or small values with n at random over its whole range.
  task automatic queue_random(int count);
    longint unsigned x;
    longint unsigned m;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          queue_request($urandom_range(46341, 32'h7fffffff), $urandom & 32'h7fffffff);
        end
        2: begin
          queue_request($urandom & 32'h7fffffff, $urandom_range(0, 900));
        end
        default: begin
          x = $urandom_range(0, 900);
          m = root_floor(x);
          queue_request($urandom_range(0, m + 1), x);
        end
      endcase
    end
  endtask

  // Waits for every request to be taken and every result to come back, then
  // gives the block time to settle.
  task automatic drain();
    while (pending_requests.size() > 0 || req_ch.valid || expected_binomials.size() > 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_modulus(longint unsigned p);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value_t'(p);
    modulus_copy = p & 64'h7fffffff;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.choose_count = '0;
    req_ch.square_value = '0;
    res_ch.ready = 1'b0;
    cycle_count = 0;
    any_failure = 1'b0;
    req_taken = 1'b0;
    modulus_copy = bisq_pkg::RESET_MODULUS;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset modulus: zero count and value, root
    // equal to n, root one below n, the largest root with a count one above
    // it, all-ones fields, and a moderately large root.
    queue_request(0, 0);
    queue_request(1, 0);
    queue_request(0, 1);
    queue_request(1, 1);
    queue_request(2, 3);
    queue_request(2, 4);
    queue_request(3, 16);
    queue_request(5, 24);
    queue_request(10, 400);
    queue_request(20, 400);
    queue_request(7, 99);
    queue_request(32'h7fffffff, 32'h7fffffff);
    queue_request(46341, 32'h7fffffff);
    queue_request(32'h7fffffff, 0);
    queue_request(0, 32'h55555555 & 32'h3ff);
    queue_request(500, 1000000);
    queue_random(10);
    drain();

    // Largest prime the register holds.
    write_modulus(32'h7fffffff);
    queue_request(3, 100);
    queue_request(0, 63);
    queue_random(15);
    drain();

    // A modulus just above the largest root.
    write_modulus(46343);
    queue_random(15);
    drain();

    // A small modulus, not above the roots of the first two requests, so m! vanishes there.
    write_modulus(7);
    queue_request(2, 49);
    queue_request(3, 100);
    queue_request(1, 36);
    queue_random(10);
    drain();

    // Modulus of two, where the Fermat exponent is zero.
    write_modulus(2);
    queue_request(1, 4);
    queue_request(0, 1);
    queue_random(6);
    drain();

    // Composite modulus.
    write_modulus(12);
    queue_request(2, 9);
    queue_random(8);
    drain();

    // Moduli below two give zero everywhere.
    write_modulus(1);
    queue_request(0, 0);
    queue_random(4);
    drain();
    write_modulus(0);
    queue_request(1, 32'h7fffffff);
    queue_random(4);
    drain();

    write_modulus(1000000007);
    queue_random(15);
    drain();

    if (!any_failure) begin
      $display("binomial_of_isqrt_mod_prime regression: pass");
    end else begin
      $display("binomial_of_isqrt_mod_prime regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/bisq_pkg.sv
src/bisq_if.sv
src/binomial_of_isqrt_mod_prime.sv
bench/tb_binomial_of_isqrt_mod_prime.sv
